/* rtl/delimiter_token_splitter_top_macros.svh */
// Assertion macros for the token splitter.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef DELIMITER_TOKEN_SPLITTER_TOP_MACROS_SVH
`define DELIMITER_TOKEN_SPLITTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("token splitter assertion failed");
`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("token splitter assertion failed");
`else
`define DTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/dts_pkg.sv */
// Types, character codes and classifier functions for the token splitter.
// No dependencies.
package dts_pkg;

	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_WORD  = 3'b010,
		MODE_COLON = 3'b100
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c == CH_EQUAL) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SEMI) ||
			(c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_COMMA);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

/* rtl/delimiter_token_splitter_top.sv */
// Delimiter token splitter: a character stream in, token characters out, one per transfer,
// each marked when it ends its token. Takes one character per cycle into an input register
// while not stalled; the scan step runs between that register and a four-entry result queue.
// A character that yields two results (a punctuator ending a word, or ':=') needs two output
// transfers, so a run of those is limited by the output side; otherwise the rate is
// one character per cycle while the output does not stall. The input stalls only while the
// queue has fewer than two free slots. A result is registered in the result queue before it
// is presented and can transfer at the next edge. Words are emitted one character behind the
// input, since only the next character tells where a word ends.
// Depends on dts_pkg and delimiter_token_splitter_top_macros.svh.
`include "delimiter_token_splitter_top_macros.svh"

module delimiter_token_splitter_top
	import dts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] token_char,
	output logic       token_last
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eoi_s1;
	scan_mode_t        mode_q, mode_d;
	logic [7:0]        held_q, held_d;
	result_t           queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              proc;
	logic              pop;
	logic [1:0]        push_n;
	result_t           res0, res1;

	assign proc     = valid_s1 && (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign in_stall = valid_s1 && !proc;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_in;
			eoi_s1  <= end_of_input;
		end
	end

	always_comb begin
		push_n = 2'd0;
		res0   = '{ch: held_q, last: 1'b1};
		res1   = '{ch: char_s1, last: 1'b1};
		mode_d = mode_q;
		held_d = held_q;
		unique case (mode_q)
			MODE_WORD: begin
				push_n = 2'd1;
				if (eoi_s1 || is_space(char_s1)) begin
					mode_d = MODE_IDLE;
				end else if (is_punct(char_s1)) begin
					push_n = 2'd2;
					mode_d = MODE_IDLE;
				end else if (char_s1 == CH_COLON) begin
					mode_d = MODE_COLON;
				end else begin
					res0.last = 1'b0;
					held_d    = char_s1;
				end
			end
			MODE_COLON: begin
				push_n = 2'd1;
				res0   = '{ch: CH_COLON, last: 1'b1};
				mode_d = MODE_IDLE;
				if (!eoi_s1 && (char_s1 == CH_EQUAL)) begin
					push_n = 2'd2;
					res0   = '{ch: CH_COLON, last: 1'b0};
					res1   = '{ch: CH_EQUAL, last: 1'b1};
				end else if (!eoi_s1 && is_letter(char_s1)) begin
					held_d = char_s1;
					mode_d = MODE_WORD;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (eoi_s1 || is_space(char_s1)) begin
					push_n = 2'd0;
				end else if (char_s1 == CH_COLON) begin
					mode_d = MODE_COLON;
				end else if (is_letter(char_s1) || is_digit(char_s1)) begin
					held_d = char_s1;
					mode_d = MODE_WORD;
				end else begin
					push_n = 2'd1;
					res0   = '{ch: char_s1, last: 1'b1};
				end
			end
		endcase
		if (!proc) begin
			push_n = 2'd0;
			mode_d = mode_q;
			held_d = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			held_q   <= 8'd0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			mode_q   <= mode_d;
			held_q   <= held_d;
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			cnt_q    <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
		end
	end

	assign out_valid  = (cnt_q != '0);
	assign token_char = queue_q[rd_ptr_q].ch;
	assign token_last = queue_q[rd_ptr_q].last;

	`DTS_ASSERT_NOW(a_queue_bound, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))
	`DTS_ASSERT_NOW(a_stall_only_held, clk, arst_n, in_stall, valid_s1 && (cnt_q > QCNT_W'(2)))
	`DTS_ASSERT_NEXT(a_eoi_to_idle, clk, arst_n, proc && eoi_s1, mode_q == MODE_IDLE)
	`DTS_ASSERT_NEXT(a_count_track, clk, arst_n, 1'b1,
		cnt_q == $past(cnt_q) + QCNT_W'($past(push_n)) - QCNT_W'($past(pop)))

endmodule

/* verif/token_stream_checker.sv */
// Watches both channels of the delimiter token splitter, predicts the token characters
// from the accepted input bytes and compares each output transfer in order.
// Depends on dts_pkg for the character codes and the result type.
`timescale 1ns / 100ps

module token_stream_checker
	import dts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_input,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] token_char,
	input  logic       token_last,
	output int         mismatches,
	output int         pending
);

	typedef enum logic [1:0] {
		SCAN_REST,
		SCAN_WORD,
		SCAN_COLON
	} scan_state_t;

	scan_state_t scan_state;
	logic [7:0]  held_byte;
	result_t     expected_tokens[$];

	initial begin
		mismatches = 0;
		pending = 0;
		scan_state = SCAN_REST;
		held_byte = 8'h00;
	end

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL;
	endfunction

	function automatic logic is_single(input logic [7:0] c);
		return c == CH_EQUAL || c == CH_PLUS || c == CH_MINUS || c == CH_SEMI ||
			c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	task automatic split_byte(input logic [7:0] c, input logic eoi);
		case (scan_state)
			SCAN_WORD: begin
				if (eoi || is_blank(c)) begin
					expected_tokens.push_back({held_byte, 1'b1});
					scan_state = SCAN_REST;
				end else if (is_single(c)) begin
					expected_tokens.push_back({held_byte, 1'b1});
					expected_tokens.push_back({c, 1'b1});
					scan_state = SCAN_REST;
				end else if (c == CH_COLON) begin
					expected_tokens.push_back({held_byte, 1'b1});
					scan_state = SCAN_COLON;
				end else begin
					expected_tokens.push_back({held_byte, 1'b0});
					held_byte = c;
				end
			end
			SCAN_COLON: begin
				if (!eoi && c == CH_EQUAL) begin
					expected_tokens.push_back({CH_COLON, 1'b0});
					expected_tokens.push_back({CH_EQUAL, 1'b1});
					scan_state = SCAN_REST;
				end else if (!eoi && is_alpha(c)) begin
					expected_tokens.push_back({CH_COLON, 1'b1});
					held_byte = c;
					scan_state = SCAN_WORD;
				end else begin
					expected_tokens.push_back({CH_COLON, 1'b1});
					scan_state = SCAN_REST;
				end
			end
			default: begin
				scan_state = SCAN_REST;
				if (!(eoi || is_blank(c))) begin
					if (c == CH_COLON) begin
						scan_state = SCAN_COLON;
					end else if (is_alpha(c) || is_num(c)) begin
						held_byte = c;
						scan_state = SCAN_WORD;
					end else begin
						expected_tokens.push_back({c, 1'b1});
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			scan_state = SCAN_REST;
			held_byte = 8'h00;
			expected_tokens.delete();
		end else begin
			if (in_valid && !in_stall)
				split_byte(char_in, end_of_input);
			if (out_valid && !out_stall) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, got char %h last %b",
						$time, token_char, token_last);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					if (want.ch !== token_char || want.last !== token_last) begin
						$display("%0t: expected char %h last %b, got char %h last %b",
							$time, want.ch, want.last, token_char, token_last);
						mismatches++;
					end
				end
			end
		end
		pending = expected_tokens.size();
	end

endmodule

/* verif/delimiter_token_splitter_top_tb.sv */
// Top of the delimiter token splitter testbench: clock, reset, byte stimulus and
// receiver stalls; the verdict comes from the failure count of token_stream_checker.
// Depends on dts_pkg, token_stream_checker and the delimiter_token_splitter_top RTL.
`timescale 1ns / 100ps

module delimiter_token_splitter_top_tb;
	import dts_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] char_in = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_stall = 1'b0;
	wire        in_stall;
	wire        out_valid;
	wire  [7:0] token_char;
	wire        token_last;
	int         mismatches;
	int         pending;
	int         send_idle_pct = 9;
	int         recv_stall_pct = 57;

	delimiter_token_splitter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_char(token_char),
		.token_last(token_last)
	);

	token_stream_checker tokens_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_char(token_char),
		.token_last(token_last),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic send_byte(input logic [7:0] c, input logic eoi);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [7:0] random_char(input logic [7:0] last_c);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (last_c == CH_COLON && roll < 40)
			return CH_EQUAL;
		if (roll < 40)
			return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
		if (roll < 50)
			return "0" + 8'($urandom_range(0, 9));
		if (roll < 65) begin
			case ($urandom_range(0, 2))
				0: return CH_SPACE;
				1: return CH_TAB;
				default: return CH_NL;
			endcase
		end
		if (roll < 80) begin
			case ($urandom_range(0, 6))
				0: return CH_EQUAL;
				1: return CH_PLUS;
				2: return CH_MINUS;
				3: return CH_SEMI;
				4: return CH_LPAREN;
				5: return CH_RPAREN;
				default: return CH_COMMA;
			endcase
		end
		if (roll < 88)
			return CH_COLON;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [7:0] c;
		logic [7:0] last_c;
		last_c = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte("a", 1'b0);
		send_byte("1", 1'b0);
		send_byte(CH_EQUAL, 1'b0);
		send_byte(CH_COLON, 1'b0);
		send_byte(CH_EQUAL, 1'b0);
		send_byte(CH_COLON, 1'b0);
		send_byte("z", 1'b0);
		send_byte(CH_COLON, 1'b0);
		send_byte("?", 1'b0);
		send_byte("9", 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_COLON, 1'b0);
		send_byte(CH_EQUAL, 1'b1);
		send_byte("w", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_SPACE, 1'b1);
		send_byte("a", 1'b1);
		send_byte(CH_NL, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_RPAREN, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_PLUS, 1'b0);
		send_byte(CH_MINUS, 1'b0);
		send_byte(CH_SEMI, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 9;
					recv_stall_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_stall_pct = 9;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < 316; i++) begin
				if ($urandom_range(0, 99) < 2) begin
					c = 8'($urandom_range(0, 255));
					send_byte(c, 1'b1);
				end else begin
					c = random_char(last_c);
					send_byte(c, 1'b0);
				end
				last_c = c;
			end
		end
		send_byte(8'($urandom_range(0, 255)), 1'b1);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
